>>> rtl/ekfpp_pkg.sv
// Shared types, constants and helpers of the EKF pose prediction block.
package ekfpp_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int REQ_W = 152;
   localparam int RSP_W = 272;
   localparam int NUM_W = 57;
   localparam int DEN_W = 38;
   localparam int DX_W = 46;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [32:0] INV_TWO_PI = 33'sd683565276;

   // csr register indexes
   localparam logic [1:0] CSR_NOISE_X = 2'd0;
   localparam logic [1:0] CSR_NOISE_Y = 2'd1;
   localparam logic [1:0] CSR_NOISE_H = 2'd2;
   localparam logic [1:0] CSR_TURN_THR = 2'd3;

   // multiplier operations
   localparam logic [4:0] OP_VDT = 5'd0;
   localparam logic [4:0] OP_DCOS = 5'd1;
   localparam logic [4:0] OP_DSIN = 5'd2;
   localparam logic [4:0] OP_WDT = 5'd3;
   localparam logic [4:0] OP_PHK = 5'd4;
   localparam logic [4:0] OP_PLK = 5'd5;
   localparam logic [4:0] OP_NUMX = 5'd6;
   localparam logic [4:0] OP_NUMY = 5'd7;
   localparam logic [4:0] OP_COV0 = 5'd9;
   localparam logic [4:0] OP_COV1 = 5'd10;
   localparam logic [4:0] OP_COV2 = 5'd11;
   localparam logic [4:0] OP_COV3 = 5'd12;
   localparam logic [4:0] OP_COV4 = 5'd13;
   localparam logic [4:0] OP_COV5 = 5'd14;
   localparam logic [4:0] OP_COV6 = 5'd15;
   localparam logic [4:0] OP_COV7 = 5'd16;
   localparam logic [4:0] OP_COV8 = 5'd17;
   localparam logic [4:0] OP_COV9 = 5'd18;
   localparam logic [4:0] OP_COV10 = 5'd19;
   localparam logic [4:0] OP_COV11 = 5'd20;

   typedef struct packed {
      logic [4:0] op;
      logic       mul;
      logic       wb;
      logic       capture;
      logic       commit;
      logic       cor_go;
      logic       cor_sel;
      logic       cor_save;
      logic       div_go;
      logic       div_sel;
      logic       div_save;
      logic       pos_upd;
      logic       cov_done;
      logic       out_load;
   } ctl_type;

   typedef struct packed {
      logic seen;
      logic standstill;
      logic arc;
      logic cor_done;
      logic div_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0: a = 32'h20000000;  5'd1: a = 32'h12E4051E;  5'd2: a = 32'h09FB385B;
         5'd3: a = 32'h051111D4;  5'd4: a = 32'h028B0D43;  5'd5: a = 32'h0145D7E1;
         5'd6: a = 32'h00A2F61E;  5'd7: a = 32'h00517C55;  5'd8: a = 32'h0028BE53;
         5'd9: a = 32'h00145F2F;  5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3; 5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D; 5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518; 5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146; 5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029; 5'd25: a = 32'h00000014; 5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005; 5'd28: a = 32'h00000003; 5'd29: a = 32'h00000001;
         default: a = 32'h0;
      endcase
      return $signed({2'b00, a});
   endfunction

endpackage

>>> rtl/ekf_pose_prediction.sv
// Top level of the EKF pose prediction block.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata: odometry pose, twist, elapsed
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: predicted pose and covariance
//  csr      in   csr_we                 csr_index, csr_wdata
//
// One item at a time; the next input transfer waits until the last item is done.
// First item after reset: stored only, no result. Standstill: no CORDIC, divide or multiply.
// Straight form: 30-step CORDIC, 15 multiplies.
// Arc form: two CORDIC runs, two 57-step divides, 17 multiplies.
// A full result register waits for rsp_tready; the next item is then held off.
// Synchronous active-high reset; no clearing pass.
module ekf_pose_prediction #(
   parameter int ANGLE_BITS = ekfpp_pkg::ANGLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // odo_x[31:0] odo_y[63:32] odo_heading[79:64] speed[103:80]
   // turn_rate[127:104] elapsed[151:128]
   input  logic [ekfpp_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pred_x[31:0] pred_y[63:32] pred_heading[79:64] var_xx[110:80]
   // var_yy[141:111] var_hh[172:142] cov_xy[204:173] cov_xh[236:205]
   // cov_yh[268:237], zero fill above
   output logic [ekfpp_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [23:0]                   csr_wdata
);

   ekfpp_pkg::ctl_type cmd;
   ekfpp_pkg::sts_type sts;

   ekfpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ekfpp_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_tdata(req_tdata),
      .rsp_tdata(rsp_tdata),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a transfer is in progress");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sts.cor_done && sts.div_done))
      else $error("CORDIC and divider finished together");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   a_no_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !req_tready)
      else $error("result produced with no item in flight");
`endif

endmodule

>>> rtl/ekfpp_cordic.sv
// Iterative binary-angle CORDIC: one rotation step per cycle, 30 steps.
module ekfpp_cordic #(
   parameter int ANGLE_BITS = ekfpp_pkg::ANGLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [ANGLE_BITS-1:0]  angle,
   output logic                   done,
   output logic signed [31:0]     cos_out,
   output logic signed [31:0]     sin_out
);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic [1:0] q_ff, q_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] t, r;
   logic [1:0] q0;
   logic [31:0] tq;

   always_comb begin
      t = 32'(angle) << (32 - ANGLE_BITS);
      tq = t + 32'h20000000;
      q0 = tq[31:30];
      r = t - {q0, 30'b0};
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff; q_in = q_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (go) begin
         x_in = ekfpp_pkg::CORDIC_GAIN;
         y_in = '0;
         z_in = 34'($signed(r));
         q_in = q0;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - ekfpp_pkg::atan_turn(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + ekfpp_pkg::atan_turn(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'd29) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in; q_ff <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      unique case (q_ff)
         2'd0: begin cos_out = 32'(x_ff); sin_out = 32'(y_ff); end
         2'd1: begin cos_out = 32'(-y_ff); sin_out = 32'(x_ff); end
         2'd2: begin cos_out = 32'(-x_ff); sin_out = 32'(-y_ff); end
         default: begin cos_out = 32'(y_ff); sin_out = 32'(-x_ff); end
      endcase
   end

   assign done = done_ff;

endmodule

>>> rtl/ekfpp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ekfpp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [ekfpp_pkg::NUM_W-1:0]    dividend,
   input  logic [ekfpp_pkg::DEN_W-1:0]    divisor,
   output logic                           done,
   output logic [ekfpp_pkg::NUM_W-1:0]    quotient
);

   localparam int NW = ekfpp_pkg::NUM_W;
   localparam int DW = ekfpp_pkg::DEN_W;

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0] rem_ff, rem_in, rem_sh;
   logic [DW-1:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      rem_sh = {rem_ff[DW-1:0], quo_ff[NW-1]};
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/ekfpp_ctrl.sv
// Sequencer for the prediction: steps the datapath through one item.
module ekfpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  ekfpp_pkg::sts_type  sts,
   output ekfpp_pkg::ctl_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_COR1 = 4'd2;
   localparam logic [3:0] S_COR1W = 4'd3;
   localparam logic [3:0] S_MUL = 4'd4;
   localparam logic [3:0] S_COR2 = 4'd5;
   localparam logic [3:0] S_COR2W = 4'd6;
   localparam logic [3:0] S_DIVX = 4'd7;
   localparam logic [3:0] S_DIVXW = 4'd8;
   localparam logic [3:0] S_DIVY = 4'd9;
   localparam logic [3:0] S_DIVYW = 4'd10;
   localparam logic [3:0] S_POS = 4'd11;
   localparam logic [3:0] S_COVD = 4'd12;
   localparam logic [3:0] S_OUT = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic ph_ff, ph_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      ph_in = ph_ff;
      cmd = '0;
      cmd.op = op_ff;
      cmd.wb = ph_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.seen) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end else if (sts.standstill) begin
               state_in = S_OUT;
            end else begin
               state_in = S_COR1;
            end
         end
         S_COR1: begin
            cmd.cor_go = 1'b1;
            state_in = S_COR1W;
         end
         S_COR1W: begin
            if (sts.cor_done) begin
               cmd.cor_save = 1'b1;
               op_in = sts.arc ? ekfpp_pkg::OP_WDT : ekfpp_pkg::OP_VDT;
               ph_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            ph_in = !ph_ff;
            if (ph_ff) begin
               unique case (op_ff)
                  ekfpp_pkg::OP_VDT: op_in = ekfpp_pkg::OP_DCOS;
                  ekfpp_pkg::OP_DCOS: op_in = ekfpp_pkg::OP_DSIN;
                  ekfpp_pkg::OP_DSIN: state_in = S_POS;
                  ekfpp_pkg::OP_WDT: op_in = ekfpp_pkg::OP_PHK;
                  ekfpp_pkg::OP_PHK: op_in = ekfpp_pkg::OP_PLK;
                  ekfpp_pkg::OP_PLK: state_in = S_COR2;
                  ekfpp_pkg::OP_NUMX: state_in = S_DIVX;
                  ekfpp_pkg::OP_NUMY: state_in = S_DIVY;
                  ekfpp_pkg::OP_COV11: state_in = S_COVD;
                  default: op_in = op_ff + 5'd1;
               endcase
            end
         end
         S_COR2: begin
            cmd.cor_go = 1'b1;
            cmd.cor_sel = 1'b1;
            state_in = S_COR2W;
         end
         S_COR2W: begin
            cmd.cor_sel = 1'b1;
            if (sts.cor_done) begin
               cmd.cor_save = 1'b1;
               op_in = ekfpp_pkg::OP_NUMX;
               ph_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_DIVX: begin
            cmd.div_go = 1'b1;
            state_in = S_DIVXW;
         end
         S_DIVXW: begin
            if (sts.div_done) begin
               cmd.div_save = 1'b1;
               op_in = ekfpp_pkg::OP_NUMY;
               ph_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_DIVY: begin
            cmd.div_go = 1'b1;
            cmd.div_sel = 1'b1;
            state_in = S_DIVYW;
         end
         S_DIVYW: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.div_save = 1'b1;
               state_in = S_POS;
            end
         end
         S_POS: begin
            cmd.pos_upd = 1'b1;
            op_in = ekfpp_pkg::OP_COV0;
            ph_in = 1'b0;
            state_in = S_MUL;
         end
         S_COVD: begin
            cmd.cov_done = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= ekfpp_pkg::OP_VDT;
         ph_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         ph_ff <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/ekfpp_dp.sv
// Datapath: state registers, shared multiplier, CORDIC and divider.
module ekfpp_dp #(
   parameter int ANGLE_BITS = ekfpp_pkg::ANGLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ekfpp_pkg::REQ_W-1:0]    req_tdata,
   output logic [ekfpp_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [23:0]                    csr_wdata,
   input  ekfpp_pkg::ctl_type             cmd,
   output ekfpp_pkg::sts_type             sts
);

   localparam int AB = ANGLE_BITS;
   localparam int UP = (AB >= 16) ? AB - 16 : 0;
   localparam int DN = (AB < 16) ? 16 - AB : 0;
   localparam int HALF_DN = (1 << DN) >> 1;
   localparam int HALF_UP = (1 << UP) >> 1;
   localparam int NW = ekfpp_pkg::NUM_W;
   localparam int DW = ekfpp_pkg::DEN_W;
   localparam int XW = ekfpp_pkg::DX_W;

   // configuration
   logic [23:0] noise_x_ff, noise_y_ff, noise_h_ff;
   logic [15:0] thr_ff;

   // item and pose state
   logic signed [31:0] nxt_x_ff, nxt_y_ff, prev_x_ff, prev_y_ff;
   logic [15:0] nxt_h_ff, prev_h_ff;
   logic signed [23:0] nxt_v_ff, nxt_w_ff, prev_v_ff, prev_w_ff;
   logic [23:0] dt_ff;
   logic seen_ff;
   logic signed [31:0] est_x_ff, est_y_ff;
   logic [15:0] est_h_ff;
   logic signed [31:0] cxx_ff, cyy_ff, chh_ff, cxy_ff, cxh_ff, cyh_ff;

   // working registers
   logic signed [31:0] cb_ff, sb_ff, ca_ff, sa_ff;
   logic signed [32:0] d_ff;
   logic signed [XW-1:0] dx_ff, dy_ff;
   logic [47:0] p_ff;
   logic [63:0] acc_ff;
   logic signed [NW-1:0] num_ff;
   logic neg_ff;
   logic signed [31:0] fa_ff, fb_ff, tmp_ff;
   logic signed [35:0] axx_ff, ayy_ff, axy_ff, axh_ff, ayh_ff;
   logic signed [65:0] prod_ff;
   logic [ekfpp_pkg::RSP_W-1:0] rsp_ff;

   // angles
   logic [16:0] hsum;
   logic [24:0] base_w;
   logic [AB-1:0] base, turn, ang_a;
   logic [63:0] tsum;
   logic [AB:0] asum;
   logic [31:0] h16_w;
   logic [15:0] h16_a;

   always_comb begin
      hsum = {1'b0, prev_h_ff} + 17'(HALF_DN);
      base_w = 25'(hsum >> DN) << UP;
      base = base_w[AB-1:0];
      tsum = acc_ff + (64'd1 << (63 - AB));
      turn = tsum[63 -: AB];
      ang_a = base + turn;
      asum = {1'b0, ang_a} + (AB + 1)'(HALF_UP);
      h16_w = 32'(asum >> UP) << DN;
      h16_a = h16_w[15:0];
   end

   // CORDIC and divider units
   logic cor_done, div_done;
   logic signed [31:0] cor_c, cor_s;
   logic [NW-1:0] div_q, un, dividend;
   logic [DW-1:0] ud;
   logic signed [DW-1:0] den_s;

   ekfpp_cordic #(.ANGLE_BITS(AB)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .go     (cmd.cor_go),
      .angle  (cmd.cor_sel ? ang_a : base),
      .done   (cor_done),
      .cos_out(cor_c),
      .sin_out(cor_s)
   );

   always_comb begin
      un = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      den_s = {prev_w_ff, 14'b0};
      ud = den_s[DW-1] ? DW'(-den_s) : DW'(den_s);
      dividend = un + NW'(ud >> 1);
   end

   ekfpp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.div_go),
      .dividend(dividend),
      .divisor (ud),
      .done    (div_done),
      .quotient(div_q)
   );

   // shared multiplier operand selection
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] rnd16, rnd30;
   logic signed [31:0] mq;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         ekfpp_pkg::OP_VDT: begin mul_a = 33'(prev_v_ff); mul_b = $signed({9'b0, dt_ff}); end
         ekfpp_pkg::OP_DCOS: begin mul_a = d_ff; mul_b = 33'(cb_ff); end
         ekfpp_pkg::OP_DSIN: begin mul_a = d_ff; mul_b = 33'(sb_ff); end
         ekfpp_pkg::OP_WDT: begin mul_a = 33'(prev_w_ff); mul_b = $signed({9'b0, dt_ff}); end
         ekfpp_pkg::OP_PHK: begin
            mul_a = 33'($signed(p_ff[47:24]));
            mul_b = ekfpp_pkg::INV_TWO_PI;
         end
         ekfpp_pkg::OP_PLK: begin
            mul_a = $signed({9'b0, p_ff[23:0]});
            mul_b = ekfpp_pkg::INV_TWO_PI;
         end
         ekfpp_pkg::OP_NUMX: begin mul_a = 33'(prev_v_ff); mul_b = 33'(sa_ff) - 33'(sb_ff); end
         ekfpp_pkg::OP_NUMY: begin mul_a = 33'(prev_v_ff); mul_b = 33'(cb_ff) - 33'(ca_ff); end
         ekfpp_pkg::OP_COV0: begin mul_a = 33'(fa_ff); mul_b = 33'(cxh_ff); end
         ekfpp_pkg::OP_COV1: begin mul_a = 33'(fa_ff); mul_b = 33'(fa_ff); end
         ekfpp_pkg::OP_COV2: begin mul_a = 33'(tmp_ff); mul_b = 33'(chh_ff); end
         ekfpp_pkg::OP_COV3: begin mul_a = 33'(fb_ff); mul_b = 33'(cyh_ff); end
         ekfpp_pkg::OP_COV4: begin mul_a = 33'(fb_ff); mul_b = 33'(fb_ff); end
         ekfpp_pkg::OP_COV5: begin mul_a = 33'(tmp_ff); mul_b = 33'(chh_ff); end
         ekfpp_pkg::OP_COV6: begin mul_a = 33'(fa_ff); mul_b = 33'(cyh_ff); end
         ekfpp_pkg::OP_COV7: begin mul_a = 33'(fb_ff); mul_b = 33'(cxh_ff); end
         ekfpp_pkg::OP_COV8: begin mul_a = 33'(fa_ff); mul_b = 33'(fb_ff); end
         ekfpp_pkg::OP_COV9: begin mul_a = 33'(tmp_ff); mul_b = 33'(chh_ff); end
         ekfpp_pkg::OP_COV10: begin mul_a = 33'(fa_ff); mul_b = 33'(chh_ff); end
         ekfpp_pkg::OP_COV11: begin mul_a = 33'(fb_ff); mul_b = 33'(chh_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      rnd16 = prod_ff + 66'sd32768;
      rnd30 = prod_ff + (66'sd1 <<< 29);
      mq = ekfpp_pkg::sat32(64'(rnd16 >>> 16));
   end

   // position update terms
   logic signed [47:0] sum_x, sum_y;
   logic signed [XW-1:0] q_s;

   always_comb begin
      sum_x = 48'(prev_x_ff) + 48'(dx_ff);
      sum_y = 48'(prev_y_ff) + 48'(dy_ff);
      q_s = neg_ff ? -XW'(div_q) : XW'(div_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_x_ff <= 24'd16384;
         noise_y_ff <= 24'd16384;
         noise_h_ff <= 24'd4096;
         thr_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ekfpp_pkg::CSR_NOISE_X: noise_x_ff <= csr_wdata;
            ekfpp_pkg::CSR_NOISE_Y: noise_y_ff <= csr_wdata;
            ekfpp_pkg::CSR_NOISE_H: noise_h_ff <= csr_wdata;
            default: thr_ff <= csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         nxt_x_ff <= $signed(req_tdata[31:0]);
         nxt_y_ff <= $signed(req_tdata[63:32]);
         nxt_h_ff <= req_tdata[79:64];
         nxt_v_ff <= $signed(req_tdata[103:80]);
         nxt_w_ff <= $signed(req_tdata[127:104]);
         dt_ff <= req_tdata[151:128];
      end
      if (cmd.commit) begin
         prev_x_ff <= nxt_x_ff;
         prev_y_ff <= nxt_y_ff;
         prev_h_ff <= nxt_h_ff;
         prev_v_ff <= nxt_v_ff;
         prev_w_ff <= nxt_w_ff;
      end
      if (cmd.cor_save) begin
         if (cmd.cor_sel) begin
            ca_ff <= cor_c;
            sa_ff <= cor_s;
         end else begin
            cb_ff <= cor_c;
            sb_ff <= cor_s;
         end
      end
      if (cmd.div_go) neg_ff <= num_ff[NW-1] ^ prev_w_ff[23];
      if (cmd.div_save) begin
         if (cmd.div_sel) dy_ff <= q_s;
         else dx_ff <= q_s;
      end
      if (cmd.mul && !cmd.wb) prod_ff <= mul_a * mul_b;
      if (cmd.pos_upd) begin
         fa_ff <= ekfpp_pkg::sat32(-64'(dy_ff));
         fb_ff <= ekfpp_pkg::sat32(64'(dx_ff));
         axx_ff <= 36'(cxx_ff);
         ayy_ff <= 36'(cyy_ff);
         axy_ff <= 36'(cxy_ff);
         axh_ff <= 36'(cxh_ff);
         ayh_ff <= 36'(cyh_ff);
      end
      if (cmd.mul && cmd.wb) begin
         unique case (cmd.op)
            ekfpp_pkg::OP_VDT: d_ff <= 33'(rnd16 >>> 16);
            ekfpp_pkg::OP_DCOS: dx_ff <= XW'(rnd30 >>> 30);
            ekfpp_pkg::OP_DSIN: dy_ff <= XW'(rnd30 >>> 30);
            ekfpp_pkg::OP_WDT: p_ff <= prod_ff[47:0];
            ekfpp_pkg::OP_PHK: acc_ff <= {prod_ff[39:0], 24'b0};
            ekfpp_pkg::OP_PLK: acc_ff <= acc_ff + prod_ff[63:0];
            ekfpp_pkg::OP_NUMX, ekfpp_pkg::OP_NUMY: num_ff <= prod_ff[NW-1:0];
            ekfpp_pkg::OP_COV0: axx_ff <= axx_ff + (36'(mq) <<< 1);
            ekfpp_pkg::OP_COV2: axx_ff <= axx_ff + 36'(mq);
            ekfpp_pkg::OP_COV3: ayy_ff <= ayy_ff + (36'(mq) <<< 1);
            ekfpp_pkg::OP_COV5: ayy_ff <= ayy_ff + 36'(mq);
            ekfpp_pkg::OP_COV6, ekfpp_pkg::OP_COV7, ekfpp_pkg::OP_COV9:
               axy_ff <= axy_ff + 36'(mq);
            ekfpp_pkg::OP_COV10: axh_ff <= axh_ff + 36'(mq);
            ekfpp_pkg::OP_COV11: ayh_ff <= ayh_ff + 36'(mq);
            default: tmp_ff <= mq;   // squared and cross F terms
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff <= {3'b000, cyh_ff, cxh_ff, cxy_ff,
                    chh_ff[31] ? 31'd0 : chh_ff[30:0],
                    cyy_ff[31] ? 31'd0 : cyy_ff[30:0],
                    cxx_ff[31] ? 31'd0 : cxx_ff[30:0],
                    est_h_ff, est_y_ff, est_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         est_x_ff <= '0;
         est_y_ff <= '0;
         est_h_ff <= '0;
         cxx_ff <= 32'sd6554;
         cyy_ff <= 32'sd6554;
         chh_ff <= 32'sd3277;
         cxy_ff <= '0;
         cxh_ff <= '0;
         cyh_ff <= '0;
      end else begin
         if (cmd.commit) seen_ff <= 1'b1;
         if (cmd.pos_upd) begin
            est_x_ff <= ekfpp_pkg::sat32(64'(sum_x));
            est_y_ff <= ekfpp_pkg::sat32(64'(sum_y));
            est_h_ff <= sts.arc ? h16_a : prev_h_ff;
         end
         if (cmd.cov_done) begin
            cxx_ff <= ekfpp_pkg::sat32(64'(ekfpp_pkg::sat32(64'(axx_ff)))
                                       + $signed({40'b0, noise_x_ff}));
            cyy_ff <= ekfpp_pkg::sat32(64'(ekfpp_pkg::sat32(64'(ayy_ff)))
                                       + $signed({40'b0, noise_y_ff}));
            chh_ff <= ekfpp_pkg::sat32(64'(chh_ff) + $signed({40'b0, noise_h_ff}));
            cxy_ff <= ekfpp_pkg::sat32(64'(axy_ff));
            cxh_ff <= ekfpp_pkg::sat32(64'(axh_ff));
            cyh_ff <= ekfpp_pkg::sat32(64'(ayh_ff));
         end
      end
   end

   logic [23:0] aw;
   assign aw = prev_w_ff[23] ? 24'(-prev_w_ff) : 24'(prev_w_ff);

   always_comb begin
      sts.seen = seen_ff;
      sts.standstill = (prev_v_ff == 24'sd0) && (prev_w_ff == 24'sd0);
      sts.arc = aw > {8'b0, thr_ff};
      sts.cor_done = cor_done;
      sts.div_done = div_done;
   end

   assign rsp_tdata = rsp_ff;

endmodule

>>> dv/ekf_pose_prediction_test.sv
// Self-checking testbench for the EKF pose prediction block: directed table, then random odometry.
module ekf_pose_prediction_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AB = ekfpp_pkg::ANGLE_BITS_DEF;
   localparam int UP_SH = (AB >= 16) ? AB - 16 : 0;
   localparam int DN_SH = (AB < 16) ? 16 - AB : 0;
   localparam logic [31:0] ANG_MASK = (32'd1 << AB) - 32'd1;
   localparam longint GAIN = 652032874;
   localparam longint unsigned TURNS_PER_RAD = 683565276;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [23:0] elapsed;
      logic [23:0] turn_rate;
      logic [23:0] speed;
      logic [15:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } odo_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic [31:0] cov_yh;
      logic [31:0] cov_xh;
      logic [31:0] cov_xy;
      logic [30:0] var_hh;
      logic [30:0] var_yy;
      logic [30:0] var_xx;
      logic [15:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   typedef struct {
      odo_type  item;
      bit       typed;
      pose_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   odo_type req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   pose_type rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = ekfpp_pkg::CSR_NOISE_X;
   logic [23:0] csr_wdata = '0;

   ekf_pose_prediction u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mirror of block state
   logic [23:0] q_x, q_y, q_h;
   logic [15:0] thr;
   longint last_pos[2];
   logic [15:0] last_head;
   longint last_v, last_w;
   bit got_first;
   longint est_pos[2];
   logic [15:0] est_head;
   longint cov[6]; // xx yy hh xy xh yh

   pose_type pose_q[$];
   int errors = 0;
   int tx_idle = 0, rx_idle = 0, rx_hold = 0;

   longint atan_tab[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

   initial forever #6 clock = ~clock;

   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clamp32((a * b + 32768) >>> 16);
   endfunction

   function automatic longint rdiv(longint num, longint den);
      longint unsigned un, ud, q;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      q = (un + ud / 2) / ud;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] t, q, r;
      longint z, x, y, ddx, ddy;
      t = (ang & ANG_MASK) << (32 - AB);
      q = ((t + 32'h20000000) >> 30) & 32'd3;
      r = t - (q << 30);
      z = longint'($signed(r));
      x = GAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         ddx = y >>> i;
         ddy = x >>> i;
         if (z >= 0) begin
            x -= ddx; y += ddy; z -= atan_tab[i];
         end else begin
            x += ddx; y -= ddy; z += atan_tab[i];
         end
      end
      case (q)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic propagate(input longint dt);
      longint aw, cb, sb, ca, sa, dx, dy, d, fa, fb;
      logic [31:0] base, turn, a;
      longint unsigned prod;
      longint p[6];
      p = cov;
      aw = (last_w < 0) ? -last_w : last_w;
      base = ((((32'(last_head) + ((32'd1 << DN_SH) >> 1)) >> DN_SH) << UP_SH)) & ANG_MASK;
      rotate(base, cb, sb);
      if (aw > longint'(thr)) begin
         prod = longint'(last_w * dt) * TURNS_PER_RAD;
         turn = 32'((prod + (64'd1 << (63 - AB))) >> (64 - AB));
         a = (base + turn) & ANG_MASK;
         rotate(a, ca, sa);
         dx = rdiv(last_v * (sa - sb), last_w * 16384);
         dy = rdiv(last_v * (cb - ca), last_w * 16384);
         est_head = 16'(((a + ((32'd1 << UP_SH) >> 1)) >> UP_SH) << DN_SH);
      end else begin
         d = (last_v * dt + 32768) >>> 16;
         dx = (d * cb + (64'sd1 << 29)) >>> 30;
         dy = (d * sb + (64'sd1 << 29)) >>> 30;
         est_head = last_head;
      end
      est_pos[0] = clamp32(last_pos[0] + dx);
      est_pos[1] = clamp32(last_pos[1] + dy);
      fa = clamp32(-dy);
      fb = clamp32(dx);
      cov[0] = clamp32(clamp32(p[0] + 2 * qmul(fa, p[4]) + qmul(qmul(fa, fa), p[2]))
                       + longint'(q_x));
      cov[1] = clamp32(clamp32(p[1] + 2 * qmul(fb, p[5]) + qmul(qmul(fb, fb), p[2]))
                       + longint'(q_y));
      cov[2] = clamp32(p[2] + longint'(q_h));
      cov[3] = clamp32(p[3] + qmul(fa, p[5]) + qmul(fb, p[4]) + qmul(qmul(fa, fb), p[2]));
      cov[4] = clamp32(p[4] + qmul(fa, p[2]));
      cov[5] = clamp32(p[5] + qmul(fb, p[2]));
   endtask

   function automatic logic [30:0] var_field(longint v);
      return (v < 0) ? 31'd0 : v[30:0];
   endfunction

   // advances the mirror by one odometry transfer; returns 1 when a pose is due
   task automatic predict_pose(input odo_type it, output bit due, output pose_type r);
      r = '0;
      due = got_first;
      if (got_first) begin
         if (!(last_v == 0 && last_w == 0)) propagate(longint'(it.elapsed));
         r.x = est_pos[0][31:0];
         r.y = est_pos[1][31:0];
         r.heading = est_head;
         r.var_xx = var_field(cov[0]);
         r.var_yy = var_field(cov[1]);
         r.var_hh = var_field(cov[2]);
         r.cov_xy = cov[3][31:0];
         r.cov_xh = cov[4][31:0];
         r.cov_yh = cov[5][31:0];
      end
      got_first = 1'b1;
      last_pos[0] = longint'($signed(it.x));
      last_pos[1] = longint'($signed(it.y));
      last_head = it.heading;
      last_v = longint'($signed(it.speed));
      last_w = longint'($signed(it.turn_rate));
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      pose_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_q.size() == 0) begin
            report("unexpected transfer", rsp_tdata.x, 0);
         end else begin
            w = pose_q.pop_front();
            if (rsp_tdata.x !== w.x) report("pred_x", rsp_tdata.x, w.x);
            if (rsp_tdata.y !== w.y) report("pred_y", rsp_tdata.y, w.y);
            if (rsp_tdata.heading !== w.heading)
               report("pred_heading", rsp_tdata.heading, w.heading);
            if (rsp_tdata.var_xx !== w.var_xx) report("var_xx", rsp_tdata.var_xx, w.var_xx);
            if (rsp_tdata.var_yy !== w.var_yy) report("var_yy", rsp_tdata.var_yy, w.var_yy);
            if (rsp_tdata.var_hh !== w.var_hh) report("var_hh", rsp_tdata.var_hh, w.var_hh);
            if (rsp_tdata.cov_xy !== w.cov_xy) report("cov_xy", rsp_tdata.cov_xy, w.cov_xy);
            if (rsp_tdata.cov_xh !== w.cov_xh) report("cov_xh", rsp_tdata.cov_xh, w.cov_xh);
            if (rsp_tdata.cov_yh !== w.cov_yh) report("cov_yh", rsp_tdata.cov_yh, w.cov_yh);
         end
      end
   end

   // receiver ready: random stalls, or a long hold-off on request
   initial forever begin
      @(posedge clock);
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         repeat (rx_hold) @(posedge clock);
         rx_hold = 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   task automatic send_odo(input odo_type it, input bit typed = 0,
                           input pose_type want = '0);
      bit due;
      pose_type r;
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it;
      do @(posedge clock); while (!req_tready);
      predict_pose(it, due, r);
      if (typed) r = want;
      if (due || typed) pose_q = {pose_q, r};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pose_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csrs(input logic [23:0] nx, ny, nh, input logic [15:0] th);
      logic [1:0] idx[4] = '{ekfpp_pkg::CSR_NOISE_X, ekfpp_pkg::CSR_NOISE_Y,
                             ekfpp_pkg::CSR_NOISE_H, ekfpp_pkg::CSR_TURN_THR};
      logic [23:0] val[4];
      val = '{nx, ny, nh, {8'd0, th}};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      q_x = nx; q_y = ny; q_h = nh; thr = th;
   endtask

   function automatic odo_type random_odo();
      odo_type it;
      int kind;
      int unsigned mag;
      kind = $urandom_range(99);
      it.x = $urandom; it.y = $urandom; it.heading = 16'($urandom);
      it.speed = 24'($urandom); it.turn_rate = 24'($urandom); it.elapsed = 24'($urandom);
      if (kind < 15) return it; // raw noise over the full field ranges
      it.x = 32'($signed(25'($urandom)));
      it.y = 32'($signed(25'($urandom)));
      it.speed = 24'($signed(19'($urandom)));
      it.elapsed = 24'($urandom_range(1, 16'h4000));
      if (kind < 25) begin
         it.speed = '0; it.turn_rate = '0;
      end else if (kind < 40) begin
         // just around the arc/straight boundary
         mag = thr + $urandom_range(2) - 1;
         it.turn_rate = $urandom_range(1) ? 24'(mag) : -24'(mag);
      end else if (kind < 55) begin
         it.turn_rate = '0;
      end else begin
         it.turn_rate = 24'($signed(19'($urandom)));
      end
      return it;
   endfunction

   row_type rows[$];

   initial begin
      pose_type first_pose;
      row_type rw;
      q_x = 16384; q_y = 16384; q_h = 4096; thr = 0;
      got_first = 0; last_pos = '{0, 0}; last_head = 0; last_v = 0; last_w = 0;
      est_pos = '{0, 0}; est_head = 0; cov = '{6554, 6554, 3277, 0, 0, 0};

      first_pose = '0;
      first_pose.var_xx = 6554; first_pose.var_yy = 6554; first_pose.var_hh = 3277;

      // elapsed, turn, speed, heading, y, x; typed rows carry their pose
      rows = '{
         '{'{24'h0, 24'h0, 24'h0, 16'h7FFF, 32'h80000000, 32'h7FFFFFFF}, 0, '0},
         '{'{24'h010000, 24'h0, 24'h010000, 16'h8000, 32'hFFFF0000, 32'h00010000},
           1, first_pose},
         '{'{24'h008000, 24'h7FFFFF, 24'h7FFFFF, 16'h4000, 32'h0, 32'h0}, 0, '0},
         '{'{24'hFFFFFF, 24'h800000, 24'h800000, 16'hC000, 32'h7FFFFFFF, 32'h80000000},
           0, '0},
         '{'{24'h000100, 24'h0, 24'h0, 16'h0, 32'h0, 32'h0}, 0, '0},
         '{'{24'h000100, 24'h000001, 24'h0, 16'h0001, 32'h1, 32'h1}, 0, '0},
         '{'{24'h010000, 24'hFFFFFF, 24'h020000, 16'hFFFF, 32'h100, 32'h200}, 0, '0},
         '{'{24'hFFFFFF, 24'h800000, 24'h7FFFFF, 16'h2000, 32'h7FFFFFFF, 32'h7FFFFFFF},
           0, '0},
         '{'{24'h000001, 24'h000000, 24'h000000, 16'h8000, 32'h80000000, 32'h80000000},
           0, '0},
         '{'{24'h004000, 24'h019220, 24'hFF0000, 16'h6000, 32'h0, 32'h0}, 0, '0},
         '{'{24'hFFFFFF, 24'hFE6DE0, 24'h7FFFFF, 16'h7FFF, 32'h12345678, 32'hEDCBA987},
           0, '0},
         '{'{24'h000000, 24'h000000, 24'h000000, 16'h1234, 32'h00C80000, 32'hFF380000},
           0, '0},
         '{'{24'h00C000, 24'h000001, 24'h030000, 16'hA000, 32'h0, 32'h0}, 0, '0},
         '{'{24'h00C000, 24'h000000, 24'h000000, 16'h0, 32'h0, 32'h0}, 0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle = 14; rx_idle = 79;
      foreach (rows[i]) begin
         rw = rows[i];
         send_odo(rw.item, rw.typed, rw.want);
      end
      drain();

      // extremes first, then random settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_csrs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
            1: write_csrs(24'h0, 24'h0, 24'h0, 16'h0);
            default: write_csrs(24'($urandom), 24'($urandom), 24'($urandom),
                                16'($urandom_range(16'h2000)));
         endcase
         if (ph == 2) begin
            tx_idle = 79; rx_idle = 14;
         end else if (ph == 4) begin
            tx_idle = 0; rx_idle = 0;
         end
         for (int n = 0; n < 245; n++) begin
            // long receiver hold-off while items keep coming
            if (n == 100) rx_hold = 3000;
            send_odo(random_odo());
         end
         drain();
      end

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
